// ===== hw/rtl/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared types and constants for the Newton square root unit.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 32;
    localparam int STEPS_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    localparam logic [STEPS_W-1:0] STEP_COUNT_RST = 7'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_COUNT   = 1'b0,
        CFG_UNTIL_STABLE = 1'b1
    } cfg_idx_t;

    // divider control from the sequencer
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hw/rtl/nsr_div.sv =====
// ----------------------------------------------------------------------------
// nsr_div
// Bit-serial restoring divider: one quotient bit per cycle, dividend and
// quotient sharing one shift register.
// ----------------------------------------------------------------------------
module nsr_div #(
    parameter int DIVIDEND_W = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  nsr_pkg::div_ctrl_t          ctrl,
    input  logic [DIVIDEND_W-1:0]       dividend,
    input  logic [nsr_pkg::ROOT_W-1:0]  divisor,
    output nsr_pkg::div_stat_t          stat,
    output logic [DIVIDEND_W-1:0]       quotient
);

    localparam int DEN_W = nsr_pkg::ROOT_W;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DEN_W:0]        rem_sh;
    logic [DEN_W:0]        diff;
    logic                  ge;

    // remainder stays below the divisor, so the shifted value fits DEN_W+1 bits
    assign rem_sh = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            dq_next   = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dq_next  = {dq_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;

endmodule

// ===== hw/rtl/newton_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// newton_square_root_unit
// Newton-Raphson square root of an unsigned fixed-point radicand.
// ----------------------------------------------------------------------------
// One radicand in, one root out, both unsigned with FRAC_BITS fractional
// bits, plus the number of Newton steps run. The estimate starts at half the
// radicand (at least one LSB); each step forms (est + (rad << FRAC_BITS)/est)/2
// with truncation, saturating to all ones. Each step runs the bit-serial
// divider, which yields one quotient bit per cycle, so an item's run time
// grows with its step count and with FRAC_BITS (default Q16.16). A zero
// radicand or a step count of zero returns without running the divider.
// Items are handled one at a time; a finished result waits in the output
// register while the next item is taken in.
module newton_square_root_unit #(
    parameter int MAX_STEPS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [nsr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [nsr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [nsr_pkg::S_TDATA_W-1:0]   s_tdata,    // [31:0] radicand
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nsr_pkg::M_TDATA_W-1:0]   m_tdata     // [31:0] root, [38:32] steps_used
);

    localparam int RAD_W   = nsr_pkg::RAD_W;
    localparam int ROOT_W  = nsr_pkg::ROOT_W;
    localparam int STEPS_W = nsr_pkg::STEPS_W;
    localparam int DIV_W   = RAD_W + FRAC_BITS;
    localparam int SUM_W   = DIV_W + 1;
    localparam int CNT_W   = $clog2(MAX_STEPS + 1);
    localparam int CMP_W   = (CNT_W > STEPS_W) ? CNT_W : STEPS_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [STEPS_W-1:0]   step_count_reg, step_count_next;
    logic                 until_stable_reg, until_stable_next;
    logic [RAD_W-1:0]     rad_reg, rad_next;
    logic [ROOT_W-1:0]    est_reg, est_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic                 stable_reg, stable_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ROOT_W-1:0]    root_out_reg, root_out_next;
    logic [STEPS_W-1:0]   steps_out_reg, steps_out_next;

    nsr_pkg::div_ctrl_t   div_ctrl;
    nsr_pkg::div_stat_t   div_stat;
    logic [DIV_W-1:0]     quo;

    logic                 s_accept;
    logic [RAD_W-1:0]     s_rad;
    logic [ROOT_W-1:0]    est_init;
    logic [CMP_W-1:0]     lim_sat;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     half;
    logic [ROOT_W-1:0]    nxt;
    logic [CNT_W-1:0]     cnt_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_rad    = s_tdata[RAD_W-1:0];

    // half the radicand, never below one LSB so the divisor is non-zero
    assign est_init = ((s_rad >> 1) == '0) ? ROOT_W'(1) : (s_rad >> 1);

    assign lim_sat = (CMP_W'(step_count_reg) > CMP_W'(MAX_STEPS)) ?
                     CMP_W'(MAX_STEPS) : CMP_W'(step_count_reg);

    // update: (quotient + est) / 2 with saturation above 32 bits
    assign sum  = {1'b0, quo} + SUM_W'(est_reg);
    assign half = sum >> 1;
    assign nxt  = ((half >> ROOT_W) != '0) ? '1 : half[ROOT_W-1:0];

    assign cnt_inc = cnt_reg + 1'b1;

    always_comb begin
        step_count_next   = step_count_reg;
        until_stable_next = until_stable_reg;
        if (cfg_wr_en) begin
            case (nsr_pkg::cfg_idx_t'(cfg_addr))
                nsr_pkg::CFG_STEP_COUNT:   step_count_next   = cfg_wdata[STEPS_W-1:0];
                nsr_pkg::CFG_UNTIL_STABLE: until_stable_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        rad_next       = rad_reg;
        est_next       = est_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        stable_next    = stable_reg;
        m_tvalid_next  = m_tvalid_reg;
        root_out_next  = root_out_reg;
        steps_out_next = steps_out_reg;
        div_ctrl.start = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    rad_next    = s_rad;
                    cnt_next    = '0;
                    limit_next  = lim_sat[CNT_W-1:0];
                    stable_next = until_stable_reg;
                    if (s_rad == '0) begin
                        est_next   = '0;
                        state_next = ST_DONE;
                    end else if (lim_sat == '0) begin
                        est_next   = est_init;
                        state_next = ST_DONE;
                    end else begin
                        est_next       = est_init;
                        div_ctrl.start = 1'b1;
                        state_next     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    cnt_next = cnt_inc;
                    if (stable_reg && (nxt == est_reg)) begin
                        state_next = ST_DONE;
                    end else begin
                        est_next = nxt;
                        if (cnt_inc == limit_reg) begin
                            state_next = ST_DONE;
                        end else begin
                            div_ctrl.start = 1'b1;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    root_out_next  = est_reg;
                    steps_out_next = STEPS_W'(cnt_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            step_count_reg   <= nsr_pkg::STEP_COUNT_RST;
            until_stable_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            cnt_reg          <= '0;
            limit_reg        <= '0;
            stable_reg       <= 1'b0;
        end else begin
            state_reg        <= state_next;
            step_count_reg   <= step_count_next;
            until_stable_reg <= until_stable_next;
            m_tvalid_reg     <= m_tvalid_next;
            cnt_reg          <= cnt_next;
            limit_reg        <= limit_next;
            stable_reg       <= stable_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg       <= rad_next;
        est_reg       <= est_next;
        root_out_reg  <= root_out_next;
        steps_out_reg <= steps_out_next;
    end

    nsr_div #(
        .DIVIDEND_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend ({rad_next, {FRAC_BITS{1'b0}}}),
        .divisor  (est_next),
        .stat     (div_stat),
        .quotient (quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(nsr_pkg::M_TDATA_W - ROOT_W - STEPS_W){1'b0}},
                       steps_out_reg, root_out_reg};

`ifndef ASSERT_OFF
    // divider finishes only while a step is in progress
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider done outside a step");

    // a new item is never taken while the divider is working
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while idle");

    // the step counter never passes the item's limit
    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < limit_reg))
        else $error("step count beyond limit");

    // a completed step either restarts the divider or ends the item
    a_step_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |=> (div_stat.busy || (state_reg == ST_DONE)))
        else $error("step neither restarted nor finished");
`endif

endmodule
